### src/popc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package popc_pkg;

    // fixed field widths of the stream and the register port, and the result buffer depth
    localparam int FIELD_BITS     = 32;
    localparam int SURF_BITS      = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int BURST_DEPTH    = 3;
    localparam int BURST_BITS     = 2;

    // register reset values
    localparam logic [SURF_BITS-1:0] SURFACE_WIDTH_RESET  = 16'd640;
    localparam logic [SURF_BITS-1:0] SURFACE_HEIGHT_RESET = 16'd480;
    localparam logic                 CLOSE_RING_RESET     = 1'b0;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SURFACE_WIDTH  = 2'd0,
        CFG_SURFACE_HEIGHT = 2'd1,
        CFG_CLOSE_RING     = 2'd2
    } cfg_index_t;

    // the nine regions around and on the surface
    typedef enum logic [3:0] {
        REGION_INSIDE      = 4'd0,
        REGION_LEFT        = 4'd1,
        REGION_UPPER_LEFT  = 4'd2,
        REGION_ABOVE       = 4'd3,
        REGION_UPPER_RIGHT = 4'd4,
        REGION_RIGHT       = 4'd5,
        REGION_LOWER_RIGHT = 4'd6,
        REGION_BELOW       = 4'd7,
        REGION_LOWER_LEFT  = 4'd8
    } region_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] point_x;
        logic signed [FIELD_BITS-1:0] point_y;
        logic                         last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] out_x;
        logic signed [FIELD_BITS-1:0] out_y;
        logic                         last_of_run;
    } out_item_t;

endpackage

`default_nettype wire

### src/polyline_offscreen_point_cull.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                          | direction | item
// ---------+----------------------------------+-----------+---------------------------
// input    | s_valid / s_ready / s_data       | in        | one vertex, last_point flag
// result   | m_valid / m_ready / m_data       | out       | one emitted vertex
// config   | cfg_we / cfg_index / cfg_wdata   | in        | register write, no wait
//
// A vertex is registered on acceptance and classified in the next cycle; it moves into
// the three-slot result buffer, from which its first result shows, once the buffer is
// empty or its last result is taken. Results leave one a cycle while m_ready is high, so
// a vertex holds the buffer until all its results leave; vertices giving at most one result flow at one a cycle.
// Reset is synchronous and clears the line state and both buffers.
// With m_ready low the buffer holds and the input register takes one more vertex.

module polyline_offscreen_point_cull #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  popc_pkg::in_item_t                       s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output popc_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_we,
    input  wire logic [popc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [popc_pkg::SURF_BITS-1:0]      cfg_wdata
);
    import popc_pkg::*;

    // configuration
    logic [SURF_BITS-1:0] surface_width_reg;
    logic [SURF_BITS-1:0] surface_height_reg;
    logic                 close_ring_reg;

    // input register
    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] in_x_reg;
    logic signed [COORD_BITS-1:0] in_y_reg;
    logic                         in_last_reg;

    // line state
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic                         line_started_reg;
    logic                         dropped_pending_reg;
    region_t                      blocked_region_reg;
    logic signed [COORD_BITS-1:0] ring_x_reg;
    logic signed [COORD_BITS-1:0] ring_y_reg;
    logic                         line_started_next;
    logic                         dropped_pending_next;
    region_t                      blocked_region_next;

    // result buffer
    out_item_t                    slot_reg [BURST_DEPTH];
    logic [BURST_BITS-1:0]        head_reg;
    logic [BURST_BITS-1:0]        rem_reg;
    out_item_t                    slot_next [BURST_DEPTH];
    logic [BURST_BITS-1:0]        count_next;

    region_t                      region;
    logic                         keep;
    logic                         emit_cur;
    logic                         emit_prev;
    logic                         emit_ring;
    logic                         pop;
    logic                         advance;
    logic signed [COORD_BITS-1:0] ring_x_sel;
    logic signed [COORD_BITS-1:0] ring_y_sel;

    // configuration writes, out-of-range index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            surface_width_reg  <= SURFACE_WIDTH_RESET;
            surface_height_reg <= SURFACE_HEIGHT_RESET;
            close_ring_reg     <= CLOSE_RING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SURFACE_WIDTH:  surface_width_reg  <= cfg_wdata;
                CFG_SURFACE_HEIGHT: surface_height_reg <= cfg_wdata;
                CFG_CLOSE_RING:     close_ring_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign pop     = m_valid && m_ready;
    assign advance = in_valid_reg && ((rem_reg == '0) || ((rem_reg == BURST_BITS'(1)) && pop));
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = (rem_reg != '0);
    assign m_data  = slot_reg[head_reg];

    popc_region #(
        .COORD_BITS(COORD_BITS)
    ) u_region (
        .x              (in_x_reg),
        .y              (in_y_reg),
        .surface_width  (surface_width_reg),
        .surface_height (surface_height_reg),
        .region         (region)
    );

    // keep / drop decision
    assign keep      = !line_started_reg || (blocked_region_reg == REGION_INSIDE)
                       || (region != blocked_region_reg);
    assign emit_cur  = keep && (!line_started_reg || (prev_x_reg != in_x_reg)
                       || (prev_y_reg != in_y_reg));
    assign emit_prev = emit_cur && dropped_pending_reg;
    assign emit_ring = in_last_reg && close_ring_reg;
    assign ring_x_sel = line_started_reg ? ring_x_reg : in_x_reg;
    assign ring_y_sel = line_started_reg ? ring_y_reg : in_y_reg;

    // pack the results of this vertex into consecutive slots
    always_comb begin
        logic [BURST_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < BURST_DEPTH; i++) begin
            slot_next[i] = '0;
        end
        if (emit_prev) begin
            slot_next[idx].out_x = FIELD_BITS'(prev_x_reg);
            slot_next[idx].out_y = FIELD_BITS'(prev_y_reg);
            idx = idx + BURST_BITS'(1);
        end
        if (emit_cur) begin
            slot_next[idx].out_x = FIELD_BITS'(in_x_reg);
            slot_next[idx].out_y = FIELD_BITS'(in_y_reg);
            idx = idx + BURST_BITS'(1);
        end
        if (emit_ring) begin
            slot_next[idx].out_x = FIELD_BITS'(ring_x_sel);
            slot_next[idx].out_y = FIELD_BITS'(ring_y_sel);
            idx = idx + BURST_BITS'(1);
        end
        if (idx != '0) begin
            slot_next[idx - BURST_BITS'(1)].last_of_run = 1'b1;
        end
        count_next = idx;
    end

    // next line state
    always_comb begin
        dropped_pending_next = !keep;
        blocked_region_next  = region;
        line_started_next    = 1'b1;
        if (in_last_reg) begin
            dropped_pending_next = 1'b0;
            blocked_region_next  = REGION_INSIDE;
            line_started_next    = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            line_started_reg    <= 1'b0;
            dropped_pending_reg <= 1'b0;
            blocked_region_reg  <= REGION_INSIDE;
            head_reg            <= '0;
            rem_reg             <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                line_started_reg    <= line_started_next;
                dropped_pending_reg <= dropped_pending_next;
                blocked_region_reg  <= blocked_region_next;
                head_reg            <= '0;
                rem_reg             <= count_next;
            end else if (pop) begin
                head_reg <= head_reg + BURST_BITS'(1);
                rem_reg  <= rem_reg - BURST_BITS'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_x_reg    <= s_data.point_x[COORD_BITS-1:0];
            in_y_reg    <= s_data.point_y[COORD_BITS-1:0];
            in_last_reg <= s_data.last_point;
        end
        if (advance) begin
            prev_x_reg <= in_x_reg;
            prev_y_reg <= in_y_reg;
            if (!line_started_reg) begin
                ring_x_reg <= in_x_reg;
                ring_y_reg <= in_y_reg;
            end
            for (int i = 0; i < BURST_DEPTH; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### src/popc_region.sv
`timescale 1ns / 1ps
`default_nettype none

module popc_region #(
    parameter int COORD_BITS = 32
) (
    input  wire logic signed [COORD_BITS-1:0]       x,
    input  wire logic signed [COORD_BITS-1:0]       y,
    input  wire logic [popc_pkg::SURF_BITS-1:0]     surface_width,
    input  wire logic [popc_pkg::SURF_BITS-1:0]     surface_height,
    output popc_pkg::region_t                       region
);
    import popc_pkg::*;

    // compare width holds both a coordinate and a positive surface size
    localparam int CMP_BITS = ((COORD_BITS > SURF_BITS) ? COORD_BITS : SURF_BITS) + 1;

    logic signed [CMP_BITS-1:0] x_ext;
    logic signed [CMP_BITS-1:0] y_ext;
    logic signed [CMP_BITS-1:0] w_ext;
    logic signed [CMP_BITS-1:0] h_ext;
    logic                       left_of;
    logic                       right_of;
    logic                       above;
    logic                       below;

    // sign-extended coordinates against zero-extended surface size
    assign x_ext    = CMP_BITS'(x);
    assign y_ext    = CMP_BITS'(y);
    assign w_ext    = CMP_BITS'(signed'({1'b0, surface_width}));
    assign h_ext    = CMP_BITS'(signed'({1'b0, surface_height}));
    assign left_of  = x[COORD_BITS-1];
    assign above    = y[COORD_BITS-1];
    assign right_of = (x_ext >= w_ext);
    assign below    = (y_ext >= h_ext);

    // outcode to region number
    always_comb begin
        if (!left_of && !right_of && !above && !below) begin
            region = REGION_INSIDE;
        end else if (left_of && !above && !below) begin
            region = REGION_LEFT;
        end else if (left_of && above) begin
            region = REGION_UPPER_LEFT;
        end else if (above && !left_of && !right_of) begin
            region = REGION_ABOVE;
        end else if (above && right_of) begin
            region = REGION_UPPER_RIGHT;
        end else if (right_of && !above && !below) begin
            region = REGION_RIGHT;
        end else if (right_of && below) begin
            region = REGION_LOWER_RIGHT;
        end else if (below && !left_of && !right_of) begin
            region = REGION_BELOW;
        end else begin
            region = REGION_LOWER_LEFT;
        end
    end

endmodule

`default_nettype wire

### src/popc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module popc_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input popc_pkg::out_item_t m_data
);
    import popc_pkg::*;

    // a stalled result stays put
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side is open after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // an empty result buffer never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

endmodule

bind polyline_offscreen_point_cull popc_checker u_popc_checker (.*);

`default_nettype wire
